// ===== rtl/core/sact_pkg.sv =====
`default_nettype none

package sact_pkg;

   // Fixed widths of the block.
   localparam int VECTOR_WIDTH  = 24;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_REG_W   = 16;
   localparam int GUARD_BITS    = 8;
   localparam int TURN_W        = 32;

   // The datapath carries guard bits plus headroom for the quarter turn
   // negation and the CORDIC gain of about 1.65 on a vector of length sqrt(2).
   localparam int DATA_W = VECTOR_WIDTH + GUARD_BITS + 3;

   // Gain correction multiply, split into narrow partial products.
   localparam int GAIN_W     = 30;
   localparam int CHUNK_W    = 18;
   localparam int NUM_CHUNKS = (DATA_W + CHUNK_W - 1) / CHUNK_W;
   localparam int MAG_PAD_W  = NUM_CHUNKS * CHUNK_W;
   localparam int PROD_W     = CHUNK_W + GAIN_W;
   localparam int ACC_W      = MAG_PAD_W + GAIN_W;
   localparam int ROUND_W    = DATA_W - GUARD_BITS + 1;

   localparam logic [GAIN_W-1:0] GAIN_Q30      = 30'd652032874;
   localparam logic [ACC_W-1:0]  GAIN_HALF_LSB = ACC_W'(1) << (GAIN_W - 1);
   localparam logic [DATA_W:0]   GUARD_HALF    = (DATA_W + 1)'(1) << (GUARD_BITS - 1);

   localparam logic [ROUND_W-1:0] SAT_POS = ROUND_W'({(VECTOR_WIDTH - 1){1'b1}});
   localparam logic [ROUND_W-1:0] SAT_NEG = SAT_POS + ROUND_W'(1);

   localparam logic [TURN_W-1:0] EIGHTH_TURN        = 32'h2000_0000;
   localparam logic [TURN_W-1:0] QUARTER_TURN       = 32'h4000_0000;
   localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

   // Accepting edge to the edge that takes the result, in clock cycles.
   localparam int LATENCY = CORDIC_STAGES + 6;

   // Register file.
   localparam int ADDR_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ANGLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ANGLE = 1'b1;
   localparam logic [ANGLE_REG_W-1:0] X_ANGLE_RESET = 16'h0000;
   localparam logic [ANGLE_REG_W-1:0] Y_ANGLE_RESET = 16'h4000;

   typedef enum logic [1:0] {
      QTR_0,
      QTR_90,
      QTR_180,
      QTR_270
   } quadrant_type;

   // Control that travels with each word down the pipeline.
   typedef struct packed {
      logic vld;
      logic err;
      logic rtype;
   } tag_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [TURN_W-1:0] z;
   } lane_type;

   // Register angle to a 32-bit binary angle, wrapped to ANGLE_BITS.
   function automatic logic [TURN_W-1:0] to_turn32(input logic [ANGLE_REG_W-1:0] reg_val);
      logic [TURN_W-1:0] ext;
      ext = {{(TURN_W - ANGLE_REG_W){reg_val[ANGLE_REG_W-1]}}, reg_val};
      return {ext[ANGLE_BITS-1:0], {(TURN_W - ANGLE_BITS){1'b0}}};
   endfunction

   // floor(atan(2^-i) / (2*pi) * 2^32)
   function automatic logic [TURN_W-1:0] atan_entry(input int idx);
      logic [TURN_W-1:0] val;
      case (idx)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051D;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2E;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2F9;
         15: val = 32'h0000_517C;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A2F;
         19: val = 32'h0000_0517;
         20: val = 32'h0000_028B;
         21: val = 32'h0000_0145;
         22: val = 32'h0000_00A2;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0028;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         28: val = 32'h0000_0002;
         29: val = 32'h0000_0001;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/skewed_axis_coordinate_transform.sv =====
// Skewed-axis coordinate transform.
// Converts a signed Q15.8 offset vector between camera axes and mount axes
// whose y axis may be skewed or reversed. req_type 0 maps camera to mount,
// 1 maps mount to camera. A word is taken at a rising edge where start is
// high and busy is low; busy stays low, so a word may enter every cycle.
// Each word gives one result word, shown on the rsp_ ports for one cycle
// with rsp_valid high. Throughput is one word per cycle: two CORDIC lanes
// of one register stage per micro-rotation, behind an input stage and a
// quarter turn stage, followed by four stages of gain correction, rounding
// and saturation.
// A word with req_vec_valid low gives rsp_error high and zero outputs.
// The receiver cannot hold results off; every result is taken as shown.
// The x_angle and y_angle registers sit on the APB port at byte addresses
// 0 and 4. The user must write them only while no word is in flight; the
// block itself does not enforce this. Reset empties the pipeline and sets
// x_angle to zero and y_angle to a quarter turn.
`default_nettype none

module skewed_axis_coordinate_transform (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_type,
   input  logic signed [sact_pkg::VECTOR_WIDTH-1:0] req_vec_x,
   input  logic signed [sact_pkg::VECTOR_WIDTH-1:0] req_vec_y,
   input  logic                                     req_vec_valid,
   output logic                                     rsp_valid,
   output logic signed [sact_pkg::VECTOR_WIDTH-1:0] rsp_out_x,
   output logic signed [sact_pkg::VECTOR_WIDTH-1:0] rsp_out_y,
   output logic                                     rsp_error,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic        [sact_pkg::ADDR_W-1:0]       paddr,
   input  logic        [31:0]                       pwdata,
   output logic        [31:0]                       prdata,
   output logic                                     pready
);
   import sact_pkg::*;

   // Register file.
   logic [ANGLE_REG_W-1:0] x_angle_ff, x_angle_in;
   logic [ANGLE_REG_W-1:0] y_angle_ff, y_angle_in;
   logic [CSR_IDX_W-1:0]   csr_idx;
   logic                   csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      x_angle_in = x_angle_ff;
      y_angle_in = y_angle_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_X_ANGLE: x_angle_in = pwdata[ANGLE_REG_W-1:0];
            CSR_Y_ANGLE: y_angle_in = pwdata[ANGLE_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_angle_ff <= X_ANGLE_RESET;
         y_angle_ff <= Y_ANGLE_RESET;
      end else begin
         x_angle_ff <= x_angle_in;
         y_angle_ff <= y_angle_in;
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_X_ANGLE: prdata = {{(32 - ANGLE_REG_W){x_angle_ff[ANGLE_REG_W-1]}}, x_angle_ff};
         CSR_Y_ANGLE: prdata = {{(32 - ANGLE_REG_W){y_angle_ff[ANGLE_REG_W-1]}}, y_angle_ff};
         default:     prdata = '0;
      endcase
   end

   // Datapath.
   logic           accept;
   tag_type        tag_pre, tag_cordic;
   lane_type [1:0] lanes_pre, lanes_cordic;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   sact_prerot u_prerot (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_type),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .vec_valid (req_vec_valid),
      .x_angle   (x_angle_ff),
      .y_angle   (y_angle_ff),
      .tag_out   (tag_pre),
      .lanes_out (lanes_pre)
   );

   sact_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (tag_pre),
      .lanes_in  (lanes_pre),
      .tag_out   (tag_cordic),
      .lanes_out (lanes_cordic)
   );

   sact_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (tag_cordic),
      .lanes_in  (lanes_cordic),
      .rsp_valid (rsp_valid),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_error (rsp_error)
   );

   // Every accepted word comes out as one result.
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted word did not produce a result");

   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching accepted word");

   a_err_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error == !$past(req_vec_valid, LATENCY)))
      else $error("error flag does not match the input word");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_out_x == '0) && (rsp_out_y == '0))
      else $error("invalid word produced nonzero outputs");

endmodule

`default_nettype wire

// ===== rtl/core/sact_prerot.sv =====
`default_nettype none

module sact_prerot (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  logic                                      req_type,
   input  logic signed [sact_pkg::VECTOR_WIDTH-1:0]  vec_x,
   input  logic signed [sact_pkg::VECTOR_WIDTH-1:0]  vec_y,
   input  logic                                      vec_valid,
   input  logic        [sact_pkg::ANGLE_REG_W-1:0]   x_angle,
   input  logic        [sact_pkg::ANGLE_REG_W-1:0]   y_angle,
   output sact_pkg::tag_type                         tag_out,
   output sact_pkg::lane_type [1:0]                  lanes_out
);
   import sact_pkg::*;

   // Exact rotation by a multiple of a quarter turn, residual angle kept in z.
   function automatic lane_type quarter_rot(
      input quadrant_type            quad,
      input logic signed [DATA_W-1:0] sx,
      input logic signed [DATA_W-1:0] sy,
      input logic signed [TURN_W-1:0] resid
   );
      lane_type res;
      res.z = resid;
      case (quad)
         QTR_90: begin
            res.x = -sy;
            res.y = sx;
         end
         QTR_180: begin
            res.x = -sx;
            res.y = -sy;
         end
         QTR_270: begin
            res.x = sy;
            res.y = -sx;
         end
         default: begin
            res.x = sx;
            res.y = sy;
         end
      endcase
      return res;
   endfunction

   // Stage 0: capture the word and derive the two rotation angles.
   tag_type                        tag0_in, tag0_ff;
   logic signed [VECTOR_WIDTH-1:0] vx0_ff, vy0_ff;
   logic [1:0][TURN_W-1:0]         ang0_in, ang0_ff;
   logic                           neg0_in, neg0_ff;
   logic [TURN_W-1:0]              xa, ya, ye;

   assign xa = to_turn32(x_angle);
   assign ya = to_turn32(y_angle);
   assign ye = xa - ya + QUARTER_TURN;

   // Lane 0 gives out_x in both directions and out_y for mount to camera.
   // Lane 1 gives out_y for camera to mount.
   assign ang0_in[0] = req_type ? xa : (TURN_W'(0) - xa);
   assign ang0_in[1] = TURN_W'(0) - (xa + ye);
   assign neg0_in    = req_type && (ye > QUARTER_TURN) && (ye < THREE_QUARTER_TURN);

   assign tag0_in.vld   = accept;
   assign tag0_in.err   = ~vec_valid;
   assign tag0_in.rtype = req_type;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else begin
         tag0_ff <= tag0_in;
      end
   end

   always_ff @(posedge clock) begin
      vx0_ff  <= vec_x;
      vy0_ff  <= vec_y;
      ang0_ff <= ang0_in;
      neg0_ff <= neg0_in;
   end

   // Stage 1: scale by the guard bits, reverse y when asked, quarter turns.
   logic signed [VECTOR_WIDTH:0] vy_wide, vy_adj;
   logic signed [DATA_W-1:0]     sx, sy;
   lane_type [1:0]               lanes1_in, lanes1_ff;
   tag_type                      tag1_ff;

   assign vy_wide = {vy0_ff[VECTOR_WIDTH-1], vy0_ff};
   assign vy_adj  = neg0_ff ? -vy_wide : vy_wide;
   assign sx = {{(DATA_W - VECTOR_WIDTH - GUARD_BITS){vx0_ff[VECTOR_WIDTH-1]}},
                vx0_ff, {GUARD_BITS{1'b0}}};
   assign sy = {{(DATA_W - VECTOR_WIDTH - 1 - GUARD_BITS){vy_adj[VECTOR_WIDTH]}},
                vy_adj, {GUARD_BITS{1'b0}}};

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [TURN_W-1:0] qsum;
      logic [TURN_W-1:0] resid;
      assign qsum  = ang0_ff[l] + EIGHTH_TURN;
      assign resid = ang0_ff[l] - {qsum[TURN_W-1 -: 2], {(TURN_W - 2){1'b0}}};
      assign lanes1_in[l] = quarter_rot(quadrant_type'(qsum[TURN_W-1 -: 2]), sx, sy,
                                        $signed(resid));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else begin
         tag1_ff <= tag0_ff;
      end
   end

   always_ff @(posedge clock) begin
      lanes1_ff <= lanes1_in;
   end

   assign tag_out   = tag1_ff;
   assign lanes_out = lanes1_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sact_cordic.sv =====
`default_nettype none

module sact_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  sact_pkg::tag_type        tag_in,
   input  sact_pkg::lane_type [1:0] lanes_in,
   output sact_pkg::tag_type        tag_out,
   output sact_pkg::lane_type [1:0] lanes_out
);
   import sact_pkg::*;

   // One micro-rotation; the step count is a constant at every call site.
   function automatic lane_type micro_rot(input lane_type src, input int step);
      logic signed [DATA_W-1:0] xv, yv, dx, dy;
      logic signed [TURN_W-1:0] zv, av;
      lane_type                 res;
      xv = src.x;
      yv = src.y;
      zv = src.z;
      dx = yv >>> step;
      dy = xv >>> step;
      av = $signed(atan_entry(step));
      if (!zv[TURN_W-1]) begin
         res.x = xv - dx;
         res.y = yv + dy;
         res.z = zv - av;
      end else begin
         res.x = xv + dx;
         res.y = yv - dy;
         res.z = zv + av;
      end
      return res;
   endfunction

   lane_type [1:0] lanes_ff [CORDIC_STAGES];
   tag_type        tag_ff   [CORDIC_STAGES];

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      lane_type [1:0] src;
      lane_type [1:0] nxt;
      tag_type        src_tag;

      if (s == 0) begin : g_first
         assign src     = lanes_in;
         assign src_tag = tag_in;
      end else begin : g_next
         assign src     = lanes_ff[s-1];
         assign src_tag = tag_ff[s-1];
      end

      assign nxt[0] = micro_rot(src[0], s);
      assign nxt[1] = micro_rot(src[1], s);

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else begin
            tag_ff[s] <= src_tag;
         end
      end

      always_ff @(posedge clock) begin
         lanes_ff[s] <= nxt;
      end
   end

   assign tag_out   = tag_ff[CORDIC_STAGES-1];
   assign lanes_out = lanes_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/sact_finish.sv =====
`default_nettype none

module sact_finish (
   input  logic                                     clock,
   input  logic                                     reset,
   input  sact_pkg::tag_type                        tag_in,
   input  sact_pkg::lane_type [1:0]                 lanes_in,
   output logic                                     rsp_valid,
   output logic signed [sact_pkg::VECTOR_WIDTH-1:0] rsp_out_x,
   output logic signed [sact_pkg::VECTOR_WIDTH-1:0] rsp_out_y,
   output logic                                     rsp_error
);
   import sact_pkg::*;

   // Component 0 is x, component 1 is y.
   logic signed [DATA_W-1:0] src [2];

   // F1: sign and magnitude.
   logic [DATA_W-1:0] mag_in [2];
   logic [DATA_W-1:0] mag_ff [2];
   logic [1:0]        neg_in, neg1_ff, neg2_ff, neg3_ff;
   tag_type           tag1_ff, tag2_ff, tag3_ff;

   assign src[0] = lanes_in[0].x;
   assign src[1] = tag_in.rtype ? lanes_in[0].y : lanes_in[1].y;

   for (genvar c = 0; c < 2; c++) begin : g_mag
      assign neg_in[c] = src[c][DATA_W-1];
      assign mag_in[c] = neg_in[c] ? DATA_W'(-src[c]) : DATA_W'(src[c]);
   end

   // F2: partial products of the gain correction.
   logic [PROD_W-1:0] pp_in [2][NUM_CHUNKS];
   logic [PROD_W-1:0] pp_ff [2][NUM_CHUNKS];

   for (genvar c = 0; c < 2; c++) begin : g_pp
      logic [MAG_PAD_W-1:0] mag_pad;
      assign mag_pad = MAG_PAD_W'(mag_ff[c]);
      for (genvar k = 0; k < NUM_CHUNKS; k++) begin : g_chunk
         assign pp_in[c][k] = PROD_W'(mag_pad[k*CHUNK_W +: CHUNK_W]) * PROD_W'(GAIN_Q30);
      end
   end

   // F3: sum the partial products and round off the gain fraction.
   logic [DATA_W-1:0] t_in [2];
   logic [DATA_W-1:0] t_ff [2];

   for (genvar c = 0; c < 2; c++) begin : g_sum
      logic [ACC_W-1:0] acc;
      always_comb begin
         acc = GAIN_HALF_LSB;
         for (int k = 0; k < NUM_CHUNKS; k++) begin
            acc = acc + (ACC_W'(pp_ff[c][k]) << (CHUNK_W * k));
         end
      end
      assign t_in[c] = acc[GAIN_W +: DATA_W];
   end

   // F4: drop the guard bits with rounding, saturate, restore the sign.
   logic [VECTOR_WIDTH-1:0] res_in [2];

   for (genvar c = 0; c < 2; c++) begin : g_round
      logic [DATA_W:0]     rsum;
      logic [ROUND_W-1:0]  rmag, lim, rsat;
      assign rsum = (DATA_W + 1)'(t_ff[c]) + GUARD_HALF;
      assign rmag = rsum[DATA_W:GUARD_BITS];
      assign lim  = neg3_ff[c] ? SAT_NEG : SAT_POS;
      assign rsat = (rmag > lim) ? lim : rmag;
      assign res_in[c] = tag3_ff.err ? '0 :
                         neg3_ff[c] ? VECTOR_WIDTH'(-rsat) : VECTOR_WIDTH'(rsat);
   end

   logic                    rsp_valid_ff;
   logic [VECTOR_WIDTH-1:0] out_x_ff, out_y_ff;
   logic                    error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= tag_in;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         rsp_valid_ff <= tag3_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg1_ff  <= neg_in;
      pp_ff    <= pp_in;
      neg2_ff  <= neg1_ff;
      t_ff     <= t_in;
      neg3_ff  <= neg2_ff;
      out_x_ff <= res_in[0];
      out_y_ff <= res_in[1];
      error_ff <= tag3_ff.err;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = $signed(out_x_ff);
   assign rsp_out_y = $signed(out_y_ff);
   assign rsp_error = error_ff;

endmodule

`default_nettype wire
